// ----- rtl/sha256_byte_stream_hasher_assert.svh -----
// Assertion macros for the byte stream hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Constants and the rotate helper shared by the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;
    localparam int unsigned NumRounds = 64;
    localparam int unsigned BlockBytes = 64;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos = 6'd56;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ----- rtl/sha256_byte_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Absorbs a message byte by byte, compresses each full 64-byte block with one
// round unit, pads on finish and streams the eight digest words.
// ----------------------------------------------------------------------------
// channel  dir  signals
// in       in   i_valid/o_ready, i_kind, i_data_byte
// out      out  o_valid/i_ready, o_digest_word, o_word_index, o_last_word
// A data byte is written into the schedule window; a byte that fills the block
// also runs the rounds and the chaining add, all through the single round unit.
// Finish: pad bytes are pushed one a cycle, compressing 1 or 2 blocks, then
// 8 output beats. Not ready while busy. Synchronous active-low reset restores
// the initial hash values; the message schedule window is not cleared.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_ADD, S_OUT} t_state;

    t_state      r_state;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [60:0] r_total;
    logic [63:0] r_bits;
    logic        r_fin;
    logic        r_len;
    logic [5:0]  r_rnd;
    logic [2:0]  r_oidx;

    logic [7:0]  pad_byte;
    logic [31:0] wt, s0, s1, w_new, t1, t2, e, a;
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        load_blk;

    // length bytes go only into the block that ends the padding
    always_comb begin
        if (r_len && r_fill >= sha_pkg::LenPos)
            pad_byte = r_bits[63:56];
        else
            pad_byte = 8'h00;
    end

    always_comb begin
        e = r_v[4];
        a = r_v[0];
        wt = r_w[0];
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        t1 = r_v[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + sha_pkg::RoundK[r_rnd] + wt;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index = r_oidx;
    assign o_last_word = (r_oidx == 3'd7);

    // Byte write into the schedule window.
    always_comb begin
        wr_en = 1'b0;
        wr_byte = i_data_byte;
        if (r_state == S_IDLE && i_valid && !i_kind) begin
            wr_en = 1'b1;
        end else if (r_state == S_PAD) begin
            wr_en = 1'b1;
            wr_byte = r_fin ? pad_byte : sha_pkg::PadByte;
        end
    end

    assign load_blk = wr_en && r_fill == 6'd63;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::InitH[i];
            end
            r_fill <= '0;
            r_total <= '0;
            r_fin <= 1'b0;
            r_len <= 1'b0;
            r_rnd <= '0;
            r_oidx <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_kind) begin
                            r_bits <= {r_total, 3'b000};
                            r_fin <= 1'b0;
                            r_len <= (r_fill < sha_pkg::LenPos);
                            r_state <= S_PAD;
                        end else begin
                            r_total <= r_total + 61'd1;
                            r_fill <= r_fill + 6'd1;
                            if (r_fill == 6'd63) begin
                                r_state <= S_ROUND;
                            end
                        end
                    end
                end
                S_PAD: begin
                    // first pad beat writes 0x80, then zeros, then length bytes in the last block
                    r_fin <= 1'b1;
                    r_fill <= r_fill + 6'd1;
                    if (r_fin && r_len && r_fill >= sha_pkg::LenPos) begin
                        r_bits <= {r_bits[55:0], 8'h00};
                    end
                    if (r_fill == 6'd63) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= e;
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= a;
                    r_v[0] <= t1 + t2;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_len) begin
                        r_oidx <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_len <= 1'b1;
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha_pkg::InitH[i];
                            end
                            r_fill <= '0;
                            r_total <= '0;
                            r_fin <= 1'b0;
                            r_len <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state != S_ROUND && r_state != S_ADD) begin
                r_rnd <= '0;
            end
            if (wr_en) begin
                r_w[r_fill[5:2]][8*(3 - r_fill[1:0]) +: 8] <= wr_byte;
            end
            // a full block starts from the current chaining words
            if (load_blk) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
        end
    end
endmodule

// ----- rtl/sha_checker.sv -----
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_kind,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_word_index,
    input logic        o_last_word,
    input logic [31:0] o_digest_word
);
    `SHA_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid, o_last_word == (o_word_index == 3'd7))
    `SHA_ASSERT_NEXT(a_busy_after_fin, i_clk, i_rst_n, i_valid && o_ready && i_kind, !o_ready)
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_last_word, o_valid && o_word_index == $past(o_word_index) + 3'd1)
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_digest_word))
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
